// ===== rtl/core/mrg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrg_pkg: shared types and constants of the maze row generator
// Field widths, cell command codes and the cell status bundle.
// ----------------------------------------------------------------------------
package mrg_pkg;

  localparam int MAX_COLUMNS_DEF = 16;
  // columns in use never exceed this, whatever the label store depth
  localparam int WIDTH_LIM       = 16;
  localparam int JOIN_W          = 15;
  localparam int DOWN_W          = 16;
  localparam int CFG_W           = 5;
  localparam logic [CFG_W-1:0] ROW_WIDTH_RST = 5'd16;

  typedef enum logic [2:0] {
    OP_IDLE,
    OP_START,
    OP_ASSIGN,
    OP_JOIN,
    OP_DOWN,
    OP_FINISH
  } cell_op_t;

  typedef enum logic [1:0] {
    TOK_HOLD,
    TOK_SHIFT,
    TOK_LOAD
  } tok_ctl_t;

  typedef struct packed {
    cell_op_t op;
    tok_ctl_t tok;
    logic     force_join;
    logic     lab_free;
  } cell_cmd_t;

  typedef struct packed {
    logic hit;
    logic pend;
    logic tok;
    logic mreq;
    logic rgt;
    logic dn;
  } cell_stat_t;

endpackage
`default_nettype wire

// ===== rtl/core/mrg_intf.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrg_intf: beat channels of the maze row generator
// Row request, row result and configuration write, each valid/ready.
// ----------------------------------------------------------------------------
interface mrg_in_if;
  logic                        valid;
  logic                        ready;
  logic [mrg_pkg::JOIN_W-1:0]  join_bits;
  logic [mrg_pkg::DOWN_W-1:0]  down_bits;
  logic                        last_row;

  modport source (output valid, join_bits, down_bits, last_row, input ready);
  modport sink   (input valid, join_bits, down_bits, last_row, output ready);
endinterface

interface mrg_out_if;
  logic                        valid;
  logic                        ready;
  logic [mrg_pkg::JOIN_W-1:0]  right_open;
  logic [mrg_pkg::DOWN_W-1:0]  down_open;
  logic                        row_done_last;

  modport source (output valid, right_open, down_open, row_done_last, input ready);
  modport sink   (input valid, right_open, down_open, row_done_last, output ready);
endinterface

interface mrg_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [mrg_pkg::CFG_W-1:0]   data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/mrg_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrg_cell: one maze column
// Holds the column's set label, carried flag, wall results and the pass
// token with its run flag, which move on to the right-hand neighbour.
// ----------------------------------------------------------------------------
module mrg_cell #(
  parameter int LW       = 4,
  parameter bit IS_FIRST = 1'b0
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  mrg_pkg::cell_cmd_t      cmd,
  input  wire  [LW-1:0]           cmd_lab,
  input  wire                     merge,
  input  wire  [LW-1:0]           mrg_from,
  input  wire  [LW-1:0]           mrg_to,
  input  wire                     in_use,
  input  wire                     use_right,
  input  wire                     join_bit,
  input  wire                     down_bit,
  input  wire  [LW-1:0]           lab_left,
  input  wire  [LW-1:0]           lab_right,
  input  wire                     tok_in,
  input  wire                     fresh_in,
  input  wire                     pend_seen_in,
  output logic                    pend_seen_out,
  output logic                    fresh_o,
  output logic [LW-1:0]           lab_o,
  output mrg_pkg::cell_stat_t     stat
);

  logic [LW-1:0] lab_r;
  logic          carry_r;
  logic          pend_r;
  logic          tok_r;
  logic          fresh_r;
  logic          rgt_r;
  logic          dn_r;

  logic grant;
  logic diff_right;
  logic fresh_eff;
  logic run_end;
  logic forced_dn;
  logic dn_set;
  logic mreq;

  always_comb begin
    grant         = pend_r & ~pend_seen_in;
    pend_seen_out = pend_seen_in | pend_r;
    diff_right    = (lab_r != lab_right);
    mreq          = tok_r & in_use & use_right & (join_bit | cmd.force_join) & diff_right;
    // a run starts at column 0 or where the label changes
    fresh_eff     = IS_FIRST | (lab_r != lab_left) | fresh_r;
    run_end       = ~use_right | diff_right;
    forced_dn     = fresh_eff & run_end;
    dn_set        = forced_dn | down_bit;
    if (forced_dn) begin
      fresh_o = 1'b1;
    end else if (down_bit) begin
      fresh_o = 1'b0;
    end else begin
      fresh_o = fresh_eff;
    end
    lab_o         = lab_r;
    stat.hit      = carry_r & in_use & (lab_r == cmd_lab);
    stat.pend     = pend_r;
    stat.tok      = tok_r;
    stat.mreq     = mreq;
    stat.rgt      = rgt_r;
    stat.dn       = dn_r;
  end

  // control flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      carry_r <= 1'b0;
      pend_r  <= 1'b0;
      tok_r   <= 1'b0;
    end else begin
      case (cmd.op)
        mrg_pkg::OP_START: begin
          pend_r <= in_use & ~carry_r;
        end
        mrg_pkg::OP_ASSIGN: begin
          if (grant && cmd.lab_free) begin
            pend_r <= 1'b0;
          end
        end
        mrg_pkg::OP_FINISH: begin
          carry_r <= dn_r;
        end
        default: begin
        end
      endcase
      case (cmd.tok)
        mrg_pkg::TOK_LOAD:  tok_r <= IS_FIRST;
        mrg_pkg::TOK_SHIFT: tok_r <= tok_in;
        default:            tok_r <= tok_r;
      endcase
    end
  end

  // label and row results
  always_ff @(posedge clk) begin
    case (cmd.op)
      mrg_pkg::OP_START: begin
        rgt_r <= 1'b0;
        dn_r  <= 1'b0;
      end
      mrg_pkg::OP_ASSIGN: begin
        if (grant && cmd.lab_free) begin
          lab_r <= cmd_lab;
        end
      end
      mrg_pkg::OP_JOIN: begin
        if (merge && in_use && (lab_r == mrg_from)) begin
          lab_r <= mrg_to;
        end
        if (mreq) begin
          rgt_r <= 1'b1;
        end
      end
      mrg_pkg::OP_DOWN: begin
        if (tok_r && in_use && dn_set) begin
          dn_r <= 1'b1;
        end
      end
      default: begin
      end
    endcase
    case (cmd.tok)
      mrg_pkg::TOK_LOAD:  fresh_r <= 1'b1;
      mrg_pkg::TOK_SHIFT: fresh_r <= fresh_in;
      default:            fresh_r <= fresh_r;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/core/maze_row_generator_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Sequence: accept, a label pass trying labels upward from 0 until every new
//   cell has one, a join pass, then a down pass (a closing join pass on the
//   last row), then the result step into the output register.
// Flow: one row at a time; a result still waiting downstream holds the result
//   step.
// Reset: carried mask cleared, row_width 16, labels undefined until assigned.
// ----------------------------------------------------------------------------
// maze_row_generator_top: Eller maze generator, one row per beat
// Controller and output register around a chain of column cells.
// ----------------------------------------------------------------------------
module maze_row_generator_top #(
  parameter int MAX_COLUMNS = mrg_pkg::MAX_COLUMNS_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  mrg_in_if.sink      in_chan,
  mrg_out_if.source   out_chan,
  mrg_cfg_if.sink     cfg_chan
);

  localparam int NCELL = (MAX_COLUMNS < mrg_pkg::WIDTH_LIM) ? MAX_COLUMNS
                                                            : mrg_pkg::WIDTH_LIM;
  localparam int LW    = $clog2(MAX_COLUMNS);
  localparam int CW    = $clog2(NCELL);
  localparam int WW    = mrg_pkg::CFG_W;
  localparam logic [WW-1:0] NCELL_W = WW'(NCELL);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ASSIGN,
    S_JOIN,
    S_FJOIN,
    S_DOWN,
    S_DONE
  } state_t;

  state_t                        state_r;
  logic [CW-1:0]                 cnt_r;
  logic [LW-1:0]                 lab_cnt_r;
  logic [mrg_pkg::JOIN_W-1:0]    join_r;
  logic [mrg_pkg::DOWN_W-1:0]    down_r;
  logic                          last_r;
  logic [WW-1:0]                 row_width_r;
  logic                          out_valid_r;
  logic [mrg_pkg::JOIN_W-1:0]    out_right_r;
  logic [mrg_pkg::DOWN_W-1:0]    out_down_r;
  logic                          out_last_r;

  mrg_pkg::cell_cmd_t            cmd;
  mrg_pkg::cell_stat_t           stat_vec [NCELL];
  logic [LW-1:0]                 lab_vec  [NCELL];
  logic [NCELL-1:0]              fresh_vec;
  logic [NCELL:0]                seen_vec;
  logic [NCELL-1:0]              use_vec;
  logic [NCELL-1:0]              hit_vec;
  logic [NCELL-1:0]              pend_vec;
  logic [NCELL-1:0]              tok_vec;
  logic [NCELL-1:0]              mreq_vec;

  logic [WW-1:0]                 eff_w;
  logic [WW-1:0]                 cnt_ext;
  logic                          join_end;
  logic                          down_end;
  logic                          accept;
  logic                          out_free;
  logic                          merge;
  logic [LW-1:0]                 mrg_from;
  logic [LW-1:0]                 mrg_to;
  logic [mrg_pkg::JOIN_W-1:0]    right_nxt;
  logic [mrg_pkg::DOWN_W-1:0]    down_nxt;

  assign in_chan.ready        = rst_n && (state_r == S_IDLE);
  assign cfg_chan.ready       = rst_n;
  assign out_chan.valid       = out_valid_r;
  assign out_chan.right_open  = out_right_r;
  assign out_chan.down_open   = out_down_r;
  assign out_chan.row_done_last = out_last_r;

  always_comb begin
    if (row_width_r < WW'(2)) begin
      eff_w = WW'(2);
    end else if (row_width_r > NCELL_W) begin
      eff_w = NCELL_W;
    end else begin
      eff_w = row_width_r;
    end
    cnt_ext  = WW'(cnt_r);
    join_end = (cnt_ext == eff_w - WW'(2));
    down_end = (cnt_ext == eff_w - WW'(1));
    accept   = in_chan.valid & in_chan.ready;
    out_free = ~out_valid_r | out_chan.ready;
  end

  always_comb begin
    merge     = |mreq_vec;
    mrg_from  = '0;
    mrg_to    = '0;
    right_nxt = '0;
    down_nxt  = '0;
    for (int i = 0; i < NCELL; i++) begin
      hit_vec[i]  = stat_vec[i].hit;
      pend_vec[i] = stat_vec[i].pend;
      tok_vec[i]  = stat_vec[i].tok;
      mreq_vec[i] = stat_vec[i].mreq;
      use_vec[i]  = (WW'(i) < eff_w);
      down_nxt[i] = stat_vec[i].dn;
      if (tok_vec[i]) begin
        mrg_to = mrg_to | lab_vec[i];
      end
      if (i < NCELL - 1) begin
        right_nxt[i] = stat_vec[i].rgt;
        if (tok_vec[i]) begin
          mrg_from = mrg_from | lab_vec[i+1];
        end
      end
    end
  end

  always_comb begin
    cmd.op         = mrg_pkg::OP_IDLE;
    cmd.tok        = mrg_pkg::TOK_HOLD;
    cmd.force_join = 1'b0;
    cmd.lab_free   = ~|hit_vec;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.op  = mrg_pkg::OP_START;
          cmd.tok = mrg_pkg::TOK_LOAD;
        end
      end
      S_ASSIGN: begin
        if (|pend_vec) begin
          cmd.op = mrg_pkg::OP_ASSIGN;
        end
      end
      S_JOIN: begin
        cmd.op  = mrg_pkg::OP_JOIN;
        cmd.tok = join_end ? mrg_pkg::TOK_LOAD : mrg_pkg::TOK_SHIFT;
      end
      S_FJOIN: begin
        cmd.op         = mrg_pkg::OP_JOIN;
        cmd.tok        = mrg_pkg::TOK_SHIFT;
        cmd.force_join = 1'b1;
      end
      S_DOWN: begin
        cmd.op  = mrg_pkg::OP_DOWN;
        cmd.tok = mrg_pkg::TOK_SHIFT;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.op = mrg_pkg::OP_FINISH;
        end
      end
      default: begin
      end
    endcase
  end

  assign seen_vec[0] = 1'b0;

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    logic [LW-1:0] lab_left;
    logic [LW-1:0] lab_right;
    logic          use_right;
    logic          join_bit;
    logic          tok_in;
    logic          fresh_in;

    if (i == 0) begin : g_first
      assign lab_left = lab_vec[0];
      assign tok_in   = 1'b0;
      assign fresh_in = 1'b1;
    end else begin : g_mid
      assign lab_left = lab_vec[i-1];
      assign tok_in   = tok_vec[i-1];
      assign fresh_in = fresh_vec[i-1];
    end

    if (i == NCELL - 1) begin : g_end
      assign lab_right = lab_vec[i];
      assign use_right = 1'b0;
    end else begin : g_inner
      assign lab_right = lab_vec[i+1];
      assign use_right = use_vec[i+1];
    end

    if (i < mrg_pkg::JOIN_W) begin : g_join
      assign join_bit = join_r[i];
    end else begin : g_nojoin
      assign join_bit = 1'b0;
    end

    mrg_cell #(
      .LW       (LW),
      .IS_FIRST (i == 0)
    ) u_cell (
      .clk           (clk),
      .rst_n         (rst_n),
      .cmd           (cmd),
      .cmd_lab       (lab_cnt_r),
      .merge         (merge),
      .mrg_from      (mrg_from),
      .mrg_to        (mrg_to),
      .in_use        (use_vec[i]),
      .use_right     (use_right),
      .join_bit      (join_bit),
      .down_bit      (down_r[i]),
      .lab_left      (lab_left),
      .lab_right     (lab_right),
      .tok_in        (tok_in),
      .fresh_in      (fresh_in),
      .pend_seen_in  (seen_vec[i]),
      .pend_seen_out (seen_vec[i+1]),
      .fresh_o       (fresh_vec[i]),
      .lab_o         (lab_vec[i]),
      .stat          (stat_vec[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      row_width_r <= mrg_pkg::ROW_WIDTH_RST;
      cnt_r       <= '0;
      lab_cnt_r   <= '0;
    end else begin
      if (cfg_chan.valid) begin
        row_width_r <= cfg_chan.data;
      end
      // in S_DONE a taken beat is always replaced by the new row
      if (out_valid_r && out_chan.ready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            join_r    <= in_chan.join_bits;
            down_r    <= in_chan.down_bits;
            last_r    <= in_chan.last_row;
            lab_cnt_r <= '0;
            state_r   <= S_ASSIGN;
          end
        end
        S_ASSIGN: begin
          // one candidate label a cycle until every fresh cell has one
          if (|pend_vec) begin
            lab_cnt_r <= lab_cnt_r + LW'(1);
          end else begin
            cnt_r   <= '0;
            state_r <= S_JOIN;
          end
        end
        S_JOIN: begin
          if (join_end) begin
            cnt_r   <= '0;
            state_r <= last_r ? S_FJOIN : S_DOWN;
          end else begin
            cnt_r <= cnt_r + CW'(1);
          end
        end
        S_FJOIN: begin
          if (join_end) begin
            state_r <= S_DONE;
          end else begin
            cnt_r <= cnt_r + CW'(1);
          end
        end
        S_DOWN: begin
          if (down_end) begin
            state_r <= S_DONE;
          end else begin
            cnt_r <= cnt_r + CW'(1);
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_right_r <= right_nxt;
            out_down_r  <= down_nxt;
            out_last_r  <= last_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // pass token is alone on the chain while a pass runs
  a_tok_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_JOIN || state_r == S_FJOIN || state_r == S_DOWN) |-> $onehot(tok_vec))
    else $error("pass token not one-hot");

  a_labels_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_JOIN) |-> (pend_vec == '0))
    else $error("join pass started with unlabelled cells");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result beat raised outside row completion");

  a_last_no_down: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> (out_down_r == '0))
    else $error("closing row opened a floor");

endmodule
`default_nettype wire
